FILE: src/gnta_pkg.sv
// ----------------------------------------------------------------------------
// Track association package
// Shared widths, operation codes and the word that circulates through the
// chain of track cells.
// ----------------------------------------------------------------------------
`default_nettype none

package gnta_pkg;

	localparam int unsigned TRACK_SLOTS_DEF = 32;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned LABEL_W  = 32;
	localparam int unsigned AGE_W    = 16;
	localparam int unsigned DIST_W   = 34;
	localparam int unsigned RETIRE_W = 6;

	typedef enum logic [1:0] {
		OP_PERSON  = 2'd0,
		OP_LEG     = 2'd1,
		OP_PURGE   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	// One track record as it travels around the ring.
	typedef struct packed {
		logic                      valid;
		logic                      claimed;
		logic signed [POS_W-1:0]   x;
		logic signed [POS_W-1:0]   y;
		logic [STAMP_W-1:0]        stamp;
		logic [LABEL_W-1:0]        label;
	} track_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

`default_nettype wire

FILE: src/gnta_cell.sv
// ----------------------------------------------------------------------------
// Track cell
// Holds one track record and hands it to the next cell when the ring shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module gnta_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire logic             clear,
	input  wire gnta_pkg::track_t prev,
	output gnta_pkg::track_t      rec
);

	gnta_pkg::track_t rec_q;

	// The whole record resets; a clear only drops the flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (clear) begin
			rec_q.valid   <= 1'b0;
			rec_q.claimed <= 1'b0;
		end else if (shift) begin
			rec_q <= prev;
		end
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

FILE: src/greedy_nearest_track_association.sv
// ----------------------------------------------------------------------------
// Greedy nearest track association
// Track table held in a ring of cells; one record is examined per cycle.
// ----------------------------------------------------------------------------
// Usage. A command is taken at a clock edge where start is high and busy is
// low; op selects a person detection, a lone-leg detection, an end-of-scan
// purge or a restart. Exactly one result follows for each command, shown on
// the result ports for one cycle and marked by done; the receiver cannot
// stall it, so each result must be captured in that cycle.
// The track records sit in a ring of TRACK_SLOTS cells. In each rotation
// of the ring, the record of slot 0 reaches the head, then slot 1,
// and so on. Detections compare each passing record against the best so far,
// then a second full rotation writes the chosen slot as it passes the head.
// Purge retires stale records as they pass in the single rotation.
// Done rises as the write rotation ends for a detection, as the single
// rotation ends for a purge and in the cycle after a restart is taken; the
// ring shows one record per cycle. busy is high from the transfer until
// done rises and a restart never raises it, so the next command may be
// taken at the edge that ends the result cycle.
// The user must write max_age_sec through cfg_valid/cfg_ready only while the
// block is idle; the block does not enforce this. cfg_ready is always high.
// Reset empties the table, clears the label counter, sets max_age_sec to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_nearest_track_association #(
	parameter int unsigned TRACK_SLOTS = gnta_pkg::TRACK_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [31:0] time_sec,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic             matched,
	output logic             created,
	output logic [31:0]      track_label,
	output logic             table_full,
	output logic [5:0]       retired_count
);

	localparam int unsigned IDX_W = $clog2(TRACK_SLOTS);
	localparam int unsigned CNT_W = IDX_W + 1;

	gnta_pkg::state_t state_q, state_d;
	gnta_pkg::track_t ring [TRACK_SLOTS];
	gnta_pkg::track_t feed;
	gnta_pkg::track_t head;

	logic [15:0] max_age_q;
	logic [1:0]  op_q;
	logic signed [15:0] x_q, y_q;
	logic [31:0] t_q;
	logic [31:0] next_label_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx;

	logic             best_ok_q;
	logic [IDX_W-1:0] best_q;
	logic [gnta_pkg::DIST_W-1:0] best_d_q;
	logic             free_ok_q;
	logic [IDX_W-1:0] free_q;
	logic [5:0]       retired_q;

	logic shift, clear, last;
	logic signed [16:0] dx, dy;
	logic [15:0] adx, ady;
	logic [31:0] sq_x, sq_y;
	logic [gnta_pkg::DIST_W-1:0] sq_dist;
	logic cand;
	logic signed [32:0] age;
	logic stale;

	// Registered outputs; done is presented for one cycle.
	logic        done_q, matched_q, created_q, full_q;
	logic [31:0] label_q;
	logic [5:0]  retcnt_q;

	assign head = ring[0];
	assign idx  = cnt_q[IDX_W-1:0];
	assign last = (cnt_q == CNT_W'(TRACK_SLOTS - 1));

	// Ring of cells: the head record returns at the tail, possibly rewritten.
	for (genvar g = 0; g < TRACK_SLOTS; g++) begin : g_cell
		gnta_pkg::track_t prev;
		if (g == TRACK_SLOTS - 1) begin : g_tail
			assign prev = feed;
		end else begin : g_mid
			assign prev = ring[g+1];
		end
		gnta_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.clear  (clear),
			.prev   (prev),
			.rec    (ring[g])
		);
	end

	// Squared distance from the detection to the record at the head. Each
	// difference fits in 16 bits as a magnitude, so the squares are exact.
	assign dx      = 17'(x_q) - 17'(head.x);
	assign dy      = 17'(y_q) - 17'(head.y);
	assign adx     = dx[16] ? 16'(-dx) : dx[15:0];
	assign ady     = dy[16] ? 16'(-dy) : dy[15:0];
	assign sq_x    = {16'd0, adx} * {16'd0, adx};
	assign sq_y    = {16'd0, ady} * {16'd0, ady};
	assign sq_dist = gnta_pkg::DIST_W'(sq_x) + gnta_pkg::DIST_W'(sq_y);
	assign cand    = head.valid && !head.claimed;

	assign age   = $signed({1'b0, t_q}) - $signed({1'b0, head.stamp});
	assign stale = head.valid && (age > $signed({17'd0, max_age_q}));

	// Record fed back into the tail while the ring rotates.
	always_comb begin
		feed = head;
		if (state_q == gnta_pkg::ST_SCAN && op_q == gnta_pkg::OP_PURGE) begin
			feed.claimed = 1'b0;
			if (stale) begin
				feed.valid = 1'b0;
			end
		end else if (state_q == gnta_pkg::ST_WRITE) begin
			if (best_ok_q && idx == best_q) begin
				feed.x       = x_q;
				feed.y       = y_q;
				feed.claimed = 1'b1;
				if (op_q == gnta_pkg::OP_PERSON) begin
					feed.stamp = t_q;
				end
			end else if (!best_ok_q && free_ok_q && op_q == gnta_pkg::OP_PERSON
					&& idx == free_q) begin
				feed.valid   = 1'b1;
				feed.claimed = 1'b1;
				feed.x       = x_q;
				feed.y       = y_q;
				feed.stamp   = t_q;
				feed.label   = next_label_q;
			end
		end
	end

	assign shift = (state_q != gnta_pkg::ST_IDLE);
	assign clear = (state_q == gnta_pkg::ST_IDLE) && start
		&& (op == gnta_pkg::OP_RESTART);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gnta_pkg::ST_IDLE: begin
				if (start && op != gnta_pkg::OP_RESTART) begin
					state_d = gnta_pkg::ST_SCAN;
				end
			end
			gnta_pkg::ST_SCAN: begin
				if (last) begin
					state_d = (op_q == gnta_pkg::OP_PURGE) ? gnta_pkg::ST_IDLE
						: gnta_pkg::ST_WRITE;
				end
			end
			gnta_pkg::ST_WRITE: begin
				if (last) begin
					state_d = gnta_pkg::ST_IDLE;
				end
			end
			default: state_d = gnta_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gnta_pkg::ST_IDLE;
			max_age_q    <= 16'd1;
			next_label_q <= '0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
			matched_q    <= 1'b0;
			created_q    <= 1'b0;
			full_q       <= 1'b0;
			label_q      <= '0;
			retcnt_q     <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				max_age_q <= cfg_data;
			end
			if (state_q == gnta_pkg::ST_IDLE) begin
				cnt_q <= '0;
				if (clear) begin
					next_label_q <= '0;
					done_q       <= 1'b1;
					matched_q    <= 1'b0;
					created_q    <= 1'b0;
					full_q       <= 1'b0;
					label_q      <= '0;
					retcnt_q     <= '0;
				end
			end else begin
				cnt_q <= last ? '0 : cnt_q + CNT_W'(1);
			end
			if (state_q == gnta_pkg::ST_SCAN && last && op_q == gnta_pkg::OP_PURGE) begin
				done_q    <= 1'b1;
				matched_q <= 1'b0;
				created_q <= 1'b0;
				full_q    <= 1'b0;
				label_q   <= '0;
				retcnt_q  <= retired_q + 6'(stale);
			end
			if (state_q == gnta_pkg::ST_WRITE && last) begin
				done_q    <= 1'b1;
				retcnt_q  <= '0;
				matched_q <= best_ok_q;
				created_q <= 1'b0;
				full_q    <= 1'b0;
				label_q   <= '0;
				if (best_ok_q) begin
					label_q <= label_q;
				end else if (op_q == gnta_pkg::OP_PERSON) begin
					if (free_ok_q) begin
						created_q    <= 1'b1;
						label_q      <= next_label_q;
						next_label_q <= next_label_q + 32'd1;
					end else begin
						full_q <= 1'b1;
					end
				end
			end
			// Capture the matched label as the chosen record passes in the write lap.
			if (state_q == gnta_pkg::ST_WRITE && best_ok_q && idx == best_q) begin
				label_q <= head.label;
			end
		end
	end

	// Command capture and per-lap search state.
	always_ff @(posedge clk) begin
		if (state_q == gnta_pkg::ST_IDLE && start) begin
			op_q      <= op;
			x_q       <= pos_x;
			y_q       <= pos_y;
			t_q       <= time_sec;
			best_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
			retired_q <= '0;
		end else if (state_q == gnta_pkg::ST_SCAN) begin
			if (cand && (!best_ok_q || sq_dist < best_d_q)) begin
				best_ok_q <= 1'b1;
				best_q    <= idx;
				best_d_q  <= sq_dist;
			end
			if (!head.valid && !free_ok_q) begin
				free_ok_q <= 1'b1;
				free_q    <= idx;
			end
			if (op_q == gnta_pkg::OP_PURGE && stale) begin
				retired_q <= retired_q + 6'd1;
			end
		end
	end

	assign busy          = (state_q != gnta_pkg::ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign done          = done_q;
	assign matched       = matched_q;
	assign created       = created_q;
	assign track_label   = label_q;
	assign table_full    = full_q;
	assign retired_count = retcnt_q;

endmodule

`default_nettype wire
